// File: rtl/core/smi_pkg.sv
// Shared types and widths for the small matrix inverse.
// No dependencies.
package smi_pkg;

    // Signed determinant accumulator: 24 terms of up to 2^124 each.
    localparam int ACC_W = 130;
    // Magnitude of a 3x3 cofactor: 6 terms of up to 2^93 each.
    localparam int COF_W = 96;
    localparam int ORDER = 4;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE, S_TERM, S_READ, S_MUL, S_ACC, S_FIN, S_DIV, S_EMIT, S_SING
    } t_state;

    // Divider status as seen by the sequencer.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic        ovf;
        logic [31:0] q;
    } t_div_res;

endpackage

// File: rtl/core/smi_div.sv
// Restoring divider, one quotient bit per cycle, low 32 quotient bits plus overflow.
// Depends on smi_pkg.
module smi_div import smi_pkg::*; #(
    parameter int NUM_W = 128,
    parameter int DEN_W = 130
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [31:0]      r_q;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, i_den}) : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[30:0], ge};
            r_ovf <= r_ovf | r_q[31];
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.q    = r_q;

endmodule

// File: rtl/core/small_matrix_inverse.sv
// Small matrix inverse (order 1..4) by adjugate over determinant, signed Q16.16.
// Loads: one item per cycle while idle; o_in_stall holds loads during inversion. Inversion: each
// determinant term is a term set-up, then per factor one store read and four 32x32 limb
// multiplies, then an accumulate; det of order n takes n! terms, each cofactor (n-1)! terms,
// and each cofactor is then divided by the determinant and emitted.
// Sync active-low reset clears control and sets the order to 4; the store is not cleared.
module small_matrix_inverse import smi_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // element load channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_row_index,
    input  logic [1:0]  i_col_index,
    input  logic signed [31:0] i_element_value,
    input  logic        i_load_last,
    // order register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_row,
    output logic [1:0]  o_out_col,
    output logic signed [31:0] o_inverse_value,
    output logic        o_singular,
    output logic        o_saturated,
    output logic        o_out_last
);

    localparam int NUM_W = COF_W + 2 * FRACTION_BITS;

    t_state r_state, n_state;

    // Permutation built from three transpositions; a2/a3/a4 form a mixed-radix count.
    function automatic logic [3:0][1:0] perm_of(input logic a2, input logic [1:0] a3,
                                                 input logic [1:0] a4);
        logic [3:0][1:0] d;
        logic [1:0]      t;
        logic [1:0]      s;
        d = {2'd3, 2'd2, 2'd1, 2'd0};
        if (a2) begin
            t = d[0]; d[0] = d[1]; d[1] = t;
        end
        if (a3 != 2'd0) begin
            s = 2'(2'd2 - a3);
            t = d[s]; d[s] = d[2]; d[2] = t;
        end
        if (a4 != 2'd0) begin
            s = 2'(2'd3 - a4);
            t = d[s]; d[s] = d[3]; d[3] = t;
        end
        return d;
    endfunction

    // element store: 16 words, synchronous read
    logic [31:0] r_store [ORDER*ORDER];
    logic [31:0] r_rd_data;
    logic [3:0]  rd_addr;
    logic        wr_en;

    logic [2:0]  r_size;
    logic [2:0]  r_n;          // effective order of this run
    logic [2:0]  r_m;          // order of the minor being expanded
    logic [2:0]  r_sr, r_sc;   // skipped row / column (4 = none)
    logic [2:0]  r_k;          // factor index within a term
    logic [1:0]  r_limb;
    logic        r_a2;
    logic [1:0]  r_a3, r_a4;
    logic [3:0][31:0] r_p;     // term magnitude, 4 limbs
    logic [31:0] r_carry;
    logic        r_tneg;
    logic signed [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_det;
    logic        r_dneg;
    logic        r_det_phase;
    logic [1:0]  r_i, r_j;
    logic        r_qneg;

    logic        r_o_valid;
    logic [1:0]  r_o_row, r_o_col;
    logic [31:0] r_o_val;
    logic        r_o_sing, r_o_sat, r_o_last;

    logic        in_acc, out_free, div_start, term_last, emit_last, acc_zero;
    logic [3:0][1:0] perm;
    logic        parity;
    logic [2:0]  row_k, col_k, dk;
    logic [31:0] mag;
    logic [63:0] prod, limb_sum;
    logic [ACC_W-1:0] acc_mag;
    logic        max2;
    logic [1:0]  max3, max4;
    logic [2:0]  n_eff;
    logic [31:0] emit_val;
    logic        emit_sat;
    t_div_res    div_res;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_o_valid || !i_out_stall;
    assign wr_en       = in_acc;

    // minor-to-matrix index mapping around the skipped row and column
    assign perm   = perm_of(r_a2, r_a3, r_a4);
    assign parity = r_a2 ^ (r_a3 != 2'd0) ^ (r_a4 != 2'd0);
    assign row_k  = r_k + {2'b0, r_k >= r_sr};
    assign dk     = {1'b0, perm[r_k[1:0]]};
    assign col_k  = dk + {2'b0, dk >= r_sc};
    assign rd_addr = {row_k[1:0], col_k[1:0]};

    assign mag      = r_rd_data[31] ? 32'(-r_rd_data) : r_rd_data;
    assign prod     = r_p[r_limb] * mag;
    assign limb_sum = prod + {32'b0, (r_limb == 2'd0) ? 32'b0 : r_carry};

    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign acc_zero = (r_acc == '0);

    assign max2 = (r_m >= 3'd2);
    assign max3 = (r_m >= 3'd3) ? 2'd2 : 2'd0;
    assign max4 = (r_m >= 3'd4) ? 2'd3 : 2'd0;
    assign term_last = (r_a2 == max2) && (r_a3 == max3) && (r_a4 == max4);

    assign n_eff = (r_size == 3'd0) ? 3'd1 : (r_size > 3'd4) ? 3'd4 : r_size;
    assign emit_last = ({1'b0, r_i} == r_n - 3'd1) && ({1'b0, r_j} == r_n - 3'd1);
    assign div_start = (r_state == S_FIN) && !r_det_phase;

    // saturate the truncated quotient to signed 32 bits
    always_comb begin
        if (r_qneg) begin
            emit_sat = div_res.ovf || (div_res.q > 32'h8000_0000);
            emit_val = emit_sat ? 32'h8000_0000 : 32'(-div_res.q);
        end else begin
            emit_sat = div_res.ovf || div_res.q[31];
            emit_val = emit_sat ? 32'h7FFF_FFFF : div_res.q;
        end
    end

    smi_div #(
        .NUM_W (NUM_W),
        .DEN_W (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({acc_mag[COF_W-1:0], {(2*FRACTION_BITS){1'b0}}}),
        .i_den   (r_det),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[{i_row_index, i_col_index}] <= i_element_value;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && i_load_last) n_state = S_TERM;
            S_TERM:  n_state = (r_m == 3'd0) ? S_ACC : S_READ;
            S_READ:  n_state = S_MUL;
            S_MUL: begin
                if (r_limb == 2'd3) begin
                    n_state = (r_k + 3'd1 == r_m) ? S_ACC : S_READ;
                end
            end
            S_ACC:   n_state = term_last ? S_FIN : S_TERM;
            S_FIN: begin
                if (!r_det_phase) begin
                    n_state = S_DIV;
                end else if (acc_zero) begin
                    n_state = S_SING;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_DIV:   if (div_res.done) n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = emit_last ? S_IDLE : S_TERM;
            S_SING:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= 3'd4;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            if ((r_state == S_EMIT || r_state == S_SING) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_load_last) begin
                    r_n         <= n_eff;
                    r_m         <= n_eff;
                    r_sr        <= 3'd4;
                    r_sc        <= 3'd4;
                    r_det_phase <= 1'b1;
                    r_acc       <= '0;
                    r_a2        <= 1'b0;
                    r_a3        <= 2'd0;
                    r_a4        <= 2'd0;
                    r_i         <= 2'd0;
                    r_j         <= 2'd0;
                end
            end
            S_TERM: begin
                r_p    <= {32'd0, 32'd0, 32'd0, 32'd1};
                r_tneg <= parity;
                r_k    <= 3'd0;
                r_limb <= 2'd0;
            end
            S_MUL: begin
                r_p[r_limb] <= limb_sum[31:0];
                r_carry     <= limb_sum[63:32];
                r_limb      <= r_limb + 2'd1;
                if (r_limb == 2'd0) begin
                    r_tneg <= r_tneg ^ r_rd_data[31];
                end
                if (r_limb == 2'd3) begin
                    r_k <= r_k + 3'd1;
                end
            end
            S_ACC: begin
                r_acc <= r_tneg ? r_acc - $signed({2'b0, r_p}) : r_acc + $signed({2'b0, r_p});
                if (r_a2 != max2) begin
                    r_a2 <= 1'b1;
                end else begin
                    r_a2 <= 1'b0;
                    if (r_a3 != max3) begin
                        r_a3 <= r_a3 + 2'd1;
                    end else begin
                        r_a3 <= 2'd0;
                        r_a4 <= (r_a4 != max4) ? r_a4 + 2'd1 : 2'd0;
                    end
                end
            end
            S_FIN: begin
                if (r_det_phase) begin
                    r_det       <= acc_mag;
                    r_dneg      <= r_acc[ACC_W-1];
                    r_det_phase <= 1'b0;
                    r_m         <= r_n - 3'd1;
                    r_sr        <= 3'd0;   // cofactor (0,0): skip row j, col i
                    r_sc        <= 3'd0;
                    r_acc       <= '0;
                end else begin
                    r_qneg <= (r_i[0] ^ r_j[0]) ^ r_acc[ACC_W-1] ^ r_dneg;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_o_row  <= r_i;
                    r_o_col  <= r_j;
                    r_o_val  <= emit_val;
                    r_o_sing <= 1'b0;
                    r_o_sat  <= emit_sat;
                    r_o_last <= emit_last;
                    r_acc    <= '0;
                    if ({1'b0, r_j} == r_n - 3'd1) begin
                        r_j  <= 2'd0;
                        r_i  <= r_i + 2'd1;
                        r_sr <= 3'd0;
                        r_sc <= {1'b0, r_i + 2'd1};
                    end else begin
                        r_j  <= r_j + 2'd1;
                        r_sr <= {1'b0, r_j + 2'd1};
                    end
                end
            end
            S_SING: begin
                if (out_free) begin
                    r_o_row  <= 2'd0;
                    r_o_col  <= 2'd0;
                    r_o_val  <= 32'd0;
                    r_o_sing <= 1'b1;
                    r_o_sat  <= 1'b0;
                    r_o_last <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_row       = r_o_row;
    assign o_out_col       = r_o_col;
    assign o_inverse_value = r_o_val;
    assign o_singular      = r_o_sing;
    assign o_saturated     = r_o_sat;
    assign o_out_last      = r_o_last;

    // a singular result is alone and final
    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_singular) |-> (o_out_last && !o_saturated))
        else $error("singular result not final");

    // factor reads stay within the minor order
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_k < r_m))
        else $error("factor index beyond minor order");

    // divider only completes while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider result unexpected");

    // a result is loaded only from an emit state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT || $past(r_state) == S_SING))
        else $error("output loaded outside emit");

endmodule

// File: tb/smi_checker.sv
`timescale 1ns / 1ps
// Result checker for small_matrix_inverse: watches the load, order-write and result channels.
// It keeps its own copy of the element store and the order, and predicts each inverse.
// Depends on: nothing outside this file.
module smi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_row_index,
    input  logic [1:0]         i_col_index,
    input  logic signed [31:0] i_element_value,
    input  logic               i_load_last,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_out_row,
    input  logic [1:0]         i_out_col,
    input  logic signed [31:0] i_inverse_value,
    input  logic               i_singular,
    input  logic               i_saturated,
    input  logic               i_out_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_inversions,
    output int                 o_singulars,
    output int                 o_results
);

    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        singular;
        logic        saturated;
        logic        last;
    } t_inv_elem;

    logic [31:0] elem_store [4][4];
    logic [2:0]  order_reg;
    t_inv_elem   inverse_q [$];

    // Exact determinant of the m x m block on rows rs and columns cs (Leibniz sum).
    function automatic logic signed [159:0] block_det(int m, int rs[4], int cs[4]);
        logic signed [159:0] acc, prod, ev;
        int d[4];
        int total, t, used, inv_cnt;
        bit ok;
        acc = 0;
        total = 1;
        for (int k = 0; k < m; k++) total = total * m;
        for (int p = 0; p < total; p++) begin
            t = p;
            used = 0;
            ok = 1;
            for (int k = 0; k < m; k++) begin
                d[k] = t % m;
                t = t / m;
                if (used[d[k]]) ok = 0;
                used[d[k]] = 1'b1;
            end
            if (ok) begin
                inv_cnt = 0;
                for (int k = 0; k < m; k++)
                    for (int l = k + 1; l < m; l++)
                        if (d[k] > d[l]) inv_cnt++;
                prod = 1;
                for (int k = 0; k < m; k++) begin
                    ev = $signed(elem_store[rs[k]][cs[d[k]]]);
                    prod = prod * ev;
                end
                if (inv_cnt % 2) acc = acc - prod;
                else acc = acc + prod;
            end
        end
        return acc;
    endfunction

    task automatic predict_inverse();
        int n, m;
        int idx[4], rs[4], cs[4];
        logic signed [159:0] det, cof;
        logic [191:0] det_mag, num, quo;
        bit neg;
        t_inv_elem e;
        n = (order_reg < 1) ? 1 : (order_reg > 4) ? 4 : int'(order_reg);
        for (int k = 0; k < 4; k++) idx[k] = k;
        det = block_det(n, idx, idx);
        o_inversions++;
        if (det == 0) begin
            e = '{row: 2'd0, col: 2'd0, value: 32'd0, singular: 1'b1,
                  saturated: 1'b0, last: 1'b1};
            inverse_q.push_back(e);
            o_singulars++;
            return;
        end
        det_mag = (det < 0) ? 192'(-det) : 192'(det);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                // adjugate: transpose of cofactors, so drop row j and column i
                m = 0;
                for (int k = 0; k < n; k++) if (k != j) rs[m++] = k;
                m = 0;
                for (int k = 0; k < n; k++) if (k != i) cs[m++] = k;
                cof = block_det(n - 1, rs, cs);
                neg = ((i + j) % 2 == 1) ^ (cof < 0) ^ (det < 0);
                num = ((cof < 0) ? 192'(-cof) : 192'(cof)) << 32;
                quo = num / det_mag;
                e.row = 2'(i);
                e.col = 2'(j);
                e.singular = 1'b0;
                e.last = (i == n - 1) && (j == n - 1);
                if (neg) begin
                    e.saturated = quo > 192'h8000_0000;
                    e.value = e.saturated ? 32'h8000_0000 : -quo[31:0];
                end else begin
                    e.saturated = quo > 192'h7FFF_FFFF;
                    e.value = e.saturated ? 32'h7FFF_FFFF : quo[31:0];
                end
                inverse_q.push_back(e);
            end
        end
    endtask

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_inv_elem e;
        if (!i_rst_n) begin
            order_reg <= 3'd4;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                order_reg <= i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (inverse_q.size() == 0) begin
                    note_mismatch("unexpected result, value", 32'hx, i_inverse_value);
                end else begin
                    e = inverse_q.pop_front();
                    if (i_out_row != e.row) note_mismatch("out_row", e.row, i_out_row);
                    if (i_out_col != e.col) note_mismatch("out_col", e.col, i_out_col);
                    if (i_inverse_value != e.value)
                        note_mismatch("inverse_value", e.value, i_inverse_value);
                    if (i_singular != e.singular)
                        note_mismatch("singular", e.singular, i_singular);
                    if (i_saturated != e.saturated)
                        note_mismatch("saturated", e.saturated, i_saturated);
                    if (i_out_last != e.last) note_mismatch("out_last", e.last, i_out_last);
                end
            end
            // store first, then invert with the updated contents
            if (i_in_valid && !i_in_stall) begin
                elem_store[i_row_index][i_col_index] = i_element_value;
                if (i_load_last) predict_inverse();
            end
        end
        o_pending <= inverse_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_inversions = 0;
        o_singulars = 0;
        o_results = 0;
    end

endmodule

// File: tb/tb_small_matrix_inverse.sv
`timescale 1ns / 1ps
// Stimulus and verdict for small_matrix_inverse; prediction lives in smi_checker.
// Depends on: smi_pkg, small_matrix_inverse, smi_checker.
module tb_small_matrix_inverse;
    import smi_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_row_index = '0;
    logic [1:0]         i_col_index = '0;
    logic signed [31:0] i_element_value = '0;
    logic               i_load_last = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_out_row;
    logic [1:0]         o_out_col;
    logic signed [31:0] o_inverse_value;
    logic               o_singular;
    logic               o_saturated;
    logic               o_out_last;

    int  fail_count, pending, inversions, singulars, results;
    // when set, neither side idles
    bit  no_idle = 1'b0;
    int  items_sent = 0;
    // order last written to the block, reset value 4
    logic [2:0] cur_order = 3'd4;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    always #2 i_clk = ~i_clk;

    small_matrix_inverse i_dut (.*);

    smi_checker i_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_row_index,
        .i_col_index, .i_element_value, .i_load_last, .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_data, .i_out_valid(o_out_valid), .i_out_stall,
        .i_out_row(o_out_row), .i_out_col(o_out_col), .i_inverse_value(o_inverse_value),
        .i_singular(o_singular), .i_saturated(o_saturated), .i_out_last(o_out_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_inversions(inversions),
        .o_singulars(singulars), .o_results(results)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result-side stall, held for random stretches
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= idle_len();
        end
    end

    // One load item; valid stays high if the next item follows at once.
    task automatic load_elem(int r, int c, logic [31:0] v, bit last);
        bit stalled;
        int gap;
        i_in_valid <= 1'b1;
        i_row_index <= 2'(r);
        i_col_index <= 2'(c);
        i_element_value <= v;
        i_load_last <= last;
        do begin
            @(negedge i_clk) stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        items_sent++;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_order(logic [2:0] n);
        bit ready;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        do begin
            @(negedge i_clk) ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready);
        i_cfg_valid <= 1'b0;
        cur_order = n;
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            default: return 32'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    // Full block of order n at effective size n; the last item triggers inversion.
    task automatic load_block(int n, bit zero_row);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                load_elem(r, c, (zero_row && r == n - 1) ? 32'd0 : rand_elem(),
                          r == n - 1 && c == n - 1);
    endtask

    int n_eff;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the whole store first with extreme values, order 4 at reset.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                load_elem(r, c, (r == c) ? ((r % 2) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                         : ((r + c) % 2 ? 32'hFFFF_FFFF : 32'h0000_0001),
                          r == 3 && c == 3);
        // identity: exact inverse
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                load_elem(r, c, (r == c) ? ONE_Q16 : 32'd0, 0);
        drain();
        load_elem(3, 3, ONE_Q16, 1);
        // singular: last row cleared
        load_elem(3, 3, 32'd0, 1);
        // order 0 acts as 1
        set_order(3'd0);
        load_elem(0, 0, ONE_Q16, 1);
        load_elem(0, 0, 32'h0000_0001, 1);   // huge positive inverse, clipped
        load_elem(0, 0, 32'hFFFF_FFFF, 1);   // huge negative inverse, clipped
        load_elem(0, 0, 32'h8000_0000, 1);
        load_elem(0, 0, 32'd0, 1);           // singular at order 1
        // order 7 acts as 4, using what the store holds now
        set_order(3'd7);
        load_elem(0, 0, ONE_Q16, 1);
        // orders 2 and 3 once, with a sender hold-off until drained
        set_order(3'd2);
        drain();
        load_block(2, 0);
        set_order(3'd3);
        load_block(3, 0);

        // Random: well-formed blocks with random content, some partial reloads
        while (items_sent < 170) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) == 0) set_order(3'($urandom_range(0, 7)));
            n_eff = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 4);
            if ($urandom_range(0, 3) != 0) begin
                if (cur_order != 3'(n_eff)) set_order(3'(n_eff));
                load_block(n_eff, $urandom_range(0, 9) == 0);
            end else begin
                // scattered reloads anywhere in the store, then invert
                repeat ($urandom_range(1, 5))
                    load_elem($urandom_range(0, 3), $urandom_range(0, 3), rand_elem(), 0);
                load_elem($urandom_range(0, 3), $urandom_range(0, 3), rand_elem(), 1);
            end
        end
        no_idle = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d load items, %0d inversions (%0d singular), %0d results",
                 items_sent, inversions, singulars, results);
        if (fail_count == 0 && pending == 0) begin
            $display("small_matrix_inverse regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("small_matrix_inverse regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("small_matrix_inverse regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/smi_pkg.sv
rtl/core/smi_div.sv
rtl/core/small_matrix_inverse.sv
tb/smi_checker.sv
tb/tb_small_matrix_inverse.sv
